// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  // Default configuration
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned PRIO_BITS_DEF = 16;
  localparam int unsigned PRIO_MAX_BITS = 32;

  // Field widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned REQ_W  = 16;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } spq_mode_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } spq_status_t;

  // Operation strobes broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic rm;
  } spq_ctl_t;

endpackage

// ===== rtl/sorted_priority_task_queue.sv =====
// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/in_tready   in_tdata: mode, task_id, priority_req
// out_      out  out_tvalid/out_tready out_tdata: served_id, status, occupancy
//
// One item per cycle: every cell compares against the item in parallel and
// shifts toward the head or tail in the same cycle; one result per item.
// The result sits in an output register from the cycle after its item is taken.
// in_tready is low only while a result waits and out_tready is low.
// Synchronous active-low reset empties the queue.
module sorted_priority_task_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [1:0] mode, [9:2] task_id, [25:10] priority_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] served_id, [9:8] status, [14:10] occupancy
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  spq_mode_t            mode;
  logic [ID_W-1:0]      task_id;
  logic [REQ_W-1:0]     priority_req;
  logic [PRIO_MAX_BITS-1:0] prio_wide;
  logic [PRIO_BITS-1:0] prio_key;

  logic [PRIO_BITS-1:0] prio_q [DEPTH];
  logic [ID_W-1:0]      id_q   [DEPTH];
  logic [DEPTH-1:0]     used_q;
  logic [DEPTH-1:0]     take_q;
  logic [DEPTH-1:0]     hit_q;

  logic [PRIO_BITS-1:0] lft_prio [DEPTH];
  logic [ID_W-1:0]      lft_id   [DEPTH];
  logic [DEPTH-1:0]     lft_used;
  logic [DEPTH-1:0]     lft_take;
  logic [PRIO_BITS-1:0] rgt_prio [DEPTH];
  logic [ID_W-1:0]      rgt_id   [DEPTH];
  logic [DEPTH-1:0]     rgt_used;
  logic [DEPTH-1:0]     hit_in;

  spq_ctl_t             ctl;
  logic                 accept;
  logic                 full, empty, found;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW+OCC_W-1:0]  occ_wide;

  logic                 out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]      served_r, served_nxt;
  spq_status_t          status_r, status_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;

  // Input unpacking
  assign mode         = spq_mode_t'(in_tdata[1:0]);
  assign task_id      = in_tdata[9:2];
  assign priority_req = in_tdata[25:10];
  assign prio_wide    = PRIO_MAX_BITS'(priority_req);
  assign prio_key     = prio_wide[PRIO_BITS-1:0];

  // Handshake
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign found = hit_q[DEPTH-1];

  assign ctl.push = accept && (mode == MODE_PUSH) && !full;
  assign ctl.pop  = accept && (mode == MODE_POP) && !empty;
  assign ctl.rm   = accept && (mode == MODE_REMOVE) && found;

  // Neighbor wiring along the chain
  assign lft_prio[0] = prio_key;
  assign lft_id[0]   = task_id;
  assign lft_used[0] = 1'b1;
  assign lft_take[0] = 1'b0;
  assign hit_in[0]   = 1'b0;
  assign rgt_prio[DEPTH-1] = '0;
  assign rgt_id[DEPTH-1]   = '0;
  assign rgt_used[DEPTH-1] = 1'b0;

  for (genvar i = 1; i < DEPTH; i++) begin : g_link
    assign lft_prio[i]   = prio_q[i-1];
    assign lft_id[i]     = id_q[i-1];
    assign lft_used[i]   = used_q[i-1];
    assign lft_take[i]   = take_q[i-1];
    assign hit_in[i]     = hit_q[i-1];
    assign rgt_prio[i-1] = prio_q[i];
    assign rgt_id[i-1]   = id_q[i];
    assign rgt_used[i-1] = used_q[i];
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .new_prio (prio_key),
      .new_id   (task_id),
      .lft_prio (lft_prio[i]),
      .lft_id   (lft_id[i]),
      .lft_used (lft_used[i]),
      .lft_take (lft_take[i]),
      .rgt_prio (rgt_prio[i]),
      .rgt_id   (rgt_id[i]),
      .rgt_used (rgt_used[i]),
      .hit_in   (hit_in[i]),
      .prio     (prio_q[i]),
      .id       (id_q[i]),
      .used     (used_q[i]),
      .take_out (take_q[i]),
      .hit_out  (hit_q[i])
    );
  end

  // Occupancy and result
  always_comb begin
    cnt_nxt    = cnt_r;
    served_nxt = '0;
    status_nxt = STAT_OK;
    if (ctl.push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (ctl.pop || ctl.rm) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (ctl.pop) begin
      served_nxt = id_q[0];
    end
    unique case (mode)
      MODE_PUSH:   if (full)   status_nxt = STAT_FULL;
      MODE_POP:    if (empty)  status_nxt = STAT_EMPTY;
      MODE_REMOVE: if (!found) status_nxt = STAT_NOT_FOUND;
      default:     status_nxt = STAT_OK;
    endcase
  end

  assign occ_wide = (CW+OCC_W)'(cnt_nxt);
  assign occ_nxt  = occ_wide[OCC_W-1:0];

  assign out_valid_nxt = accept || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= accept ? cnt_nxt : cnt_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      served_r <= served_nxt;
      status_r <= status_nxt;
      occ_r    <= occ_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, occ_r, status_r, served_r};

  // Occupied cells always form a run starting at the head
  a_used_contig: assert property (@(posedge clk) disable iff (!rst_n)
    ((used_q & (used_q + DEPTH'(1))) == '0))
    else $error("occupied cells not contiguous from head");

  // Count register tracks the number of occupied cells
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(used_q) == int'(cnt_r)))
    else $error("count disagrees with occupied cells");

  // A push that is taken grows the queue by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("push did not grow the queue");

  // A pop that is taken reports the old head
  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |=> (out_tdata[7:0] == $past(id_q[0])))
    else $error("pop did not return head id");

endmodule

// ===== rtl/spq_cell.sv =====
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spq_ctl_t             ctl,
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic [ID_W-1:0]      new_id,
  // left neighbor (toward head)
  input  logic [PRIO_BITS-1:0] lft_prio,
  input  logic [ID_W-1:0]      lft_id,
  input  logic                 lft_used,
  input  logic                 lft_take,
  // right neighbor (toward tail)
  input  logic [PRIO_BITS-1:0] rgt_prio,
  input  logic [ID_W-1:0]      rgt_id,
  input  logic                 rgt_used,
  input  logic                 hit_in,
  output logic [PRIO_BITS-1:0] prio,
  output logic [ID_W-1:0]      id,
  output logic                 used,
  output logic                 take_out,
  output logic                 hit_out
);

  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic                 used_r, used_nxt;
  logic                 pull;

  // Insert region: empty cell or new priority at least as high as ours
  assign take_out = !used_r || (new_prio >= prio_r);
  // Remove region: first matching id at or ahead of this cell
  assign hit_out  = hit_in || (used_r && (id_r == new_id));
  assign pull     = ctl.pop || (ctl.rm && hit_out);

  always_comb begin
    prio_nxt = prio_r;
    id_nxt   = id_r;
    used_nxt = used_r;
    if (ctl.push && take_out) begin
      // shift toward tail, or take the new item at the boundary
      prio_nxt = lft_take ? lft_prio : new_prio;
      id_nxt   = lft_take ? lft_id : new_id;
      used_nxt = used_r || lft_used;
    end else if (pull) begin
      // shift toward head
      prio_nxt = rgt_prio;
      id_nxt   = rgt_id;
      used_nxt = rgt_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    id_r   <= id_nxt;
  end

  assign prio = prio_r;
  assign id   = id_r;
  assign used = used_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import spq_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEF;
  localparam int unsigned PRIO_BITS  = PRIO_BITS_DEF;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned CALM_START = 600;
  localparam int unsigned CALM_END   = 1200;
  localparam int unsigned HOLD_AT    = 1500;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned DRAIN_WAIT = 10;

  // One queue operation, laid out as in in_tdata (mode in the low bits)
  typedef struct packed {
    logic [REQ_W-1:0] prio;
    logic [ID_W-1:0]  id;
    spq_mode_t        mode;
  } queue_op_t;

  // One result, laid out as in out_tdata (served id in the low bits)
  typedef struct packed {
    logic [OCC_W-1:0] occ;
    spq_status_t      status;
    logic [ID_W-1:0]  served;
  } queue_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int unsigned cycle       = 0;
  int unsigned hold_left   = 0;
  int unsigned error_count = 0;
  logic        calm;

  queue_op_t     pending_ops[$];
  queue_result_t expected_results[$];

  // Shadow copy of the sorted queue, head at index 0
  logic [PRIO_BITS-1:0] shadow_prio[DEPTH] = '{default: '0};
  logic [ID_W-1:0]      shadow_id[DEPTH]   = '{default: '0};
  int unsigned          shadow_count       = 0;

  sorted_priority_task_queue #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
  end

  // No idling on either side in this window
  assign calm = (cycle >= CALM_START) && (cycle < CALM_END);

  // Drop the shadow entry at pos and close the gap toward the head
  task automatic drop_entry(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
      shadow_prio[i] = shadow_prio[i + 1];
      shadow_id[i]   = shadow_id[i + 1];
    end
    shadow_count--;
    shadow_prio[shadow_count] = '0;
    shadow_id[shadow_count]   = '0;
  endtask

  // Apply one operation to the shadow queue and return the result it gives
  task automatic apply_queue_op(input queue_op_t op, output queue_result_t res);
    int unsigned          pos;
    logic [PRIO_BITS-1:0] p;
    p = op.prio[PRIO_BITS-1:0];
    res.served = '0;
    res.status = STAT_OK;
    case (op.mode)
      MODE_PUSH: begin
        if (shadow_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          // ties go ahead of older entries
          pos = shadow_count;
          for (int unsigned i = 0; i < shadow_count; i++) begin
            if (p >= shadow_prio[i]) begin
              pos = i;
              break;
            end
          end
          for (int unsigned i = shadow_count; i > pos; i--) begin
            shadow_prio[i] = shadow_prio[i - 1];
            shadow_id[i]   = shadow_id[i - 1];
          end
          shadow_prio[pos] = p;
          shadow_id[pos]   = op.id;
          shadow_count++;
        end
      end
      MODE_POP: begin
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.served = shadow_id[0];
          drop_entry(0);
        end
      end
      MODE_REMOVE: begin
        // copy nearest the head goes first
        pos = shadow_count;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_id[i] == op.id) begin
            pos = i;
            break;
          end
        end
        if (pos == shadow_count) res.status = STAT_NOT_FOUND;
        else drop_entry(pos);
      end
      default: ;
    endcase
    res.occ = OCC_W'(shadow_count);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Sender: offers the next pending item, idles at random outside the calm window
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {6'b0, pending_ops.pop_front()};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (cycle == HOLD_AT) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_LEN;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  // Monitor: check results against the oldest expectation, predict accepted items
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = queue_result_t'(out_tdata[14:0]);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result item", int'(out_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        if (got.served !== want.served) report_mismatch("served_id", got.served, want.served);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.occ !== want.occ) report_mismatch("occupancy", got.occ, want.occ);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      apply_queue_op(queue_op_t'(in_tdata[25:0]), want);
      expected_results.push_back(want);
    end
  end

  // Run ends here if the block hangs
  always @(posedge clk) begin
    if (cycle >= CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    queue_op_t   op;
    int unsigned push_weight;
    int unsigned r;

    // Directed: empty queue corner cases and the unused mode
    pending_ops.push_back('{prio: 16'd0, id: 8'd0, mode: MODE_POP});
    pending_ops.push_back('{prio: 16'd0, id: 8'd9, mode: MODE_REMOVE});
    pending_ops.push_back('{prio: 16'hFFFF, id: 8'hFF, mode: MODE_NONE});

    // Fill to the top and past it with extremes, ties and a duplicated id, then remove and pop
    pending_ops.push_back('{prio: 16'd100, id: 8'd5, mode: MODE_PUSH});
    pending_ops.push_back('{prio: 16'd100, id: 8'd6, mode: MODE_PUSH});
    pending_ops.push_back('{prio: 16'hFFFF, id: 8'hFF, mode: MODE_PUSH});
    pending_ops.push_back('{prio: 16'd0, id: 8'd0, mode: MODE_PUSH});
    pending_ops.push_back('{prio: 16'd0, id: 8'd1, mode: MODE_PUSH});
    pending_ops.push_back('{prio: 16'hFFFF, id: 8'd2, mode: MODE_PUSH});
    pending_ops.push_back('{prio: 16'd50, id: 8'd5, mode: MODE_PUSH});
    pending_ops.push_back('{prio: 16'd200, id: 8'd5, mode: MODE_PUSH});
    for (int i = 0; i < 8; i++) begin
      op.mode = MODE_PUSH;
      op.id   = 8'(8'hA0 + i);
      op.prio = 16'(16'h5555 << (i % 2));
      pending_ops.push_back(op);
    end
    pending_ops.push_back('{prio: 16'h8000, id: 8'd77, mode: MODE_PUSH});
    pending_ops.push_back('{prio: 16'd5, id: 8'd5, mode: MODE_REMOVE});
    pending_ops.push_back('{prio: 16'd0, id: 8'd123, mode: MODE_REMOVE});
    pending_ops.push_back('{prio: 16'd0, id: 8'd0, mode: MODE_POP});

    // Random: blocks that lean toward filling or draining the queue
    for (int blk = 0; blk < 15; blk++) begin
      case ($urandom_range(2))
        0:       push_weight = 70;
        1:       push_weight = 50;
        default: push_weight = 30;
      endcase
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(99);
        if (r < 3) op.mode = MODE_NONE;
        else if (r < 3 + push_weight) op.mode = MODE_PUSH;
        else if ($urandom_range(2) == 0) op.mode = MODE_REMOVE;
        else op.mode = MODE_POP;
        // small id pool so removes often hit
        op.id = ($urandom_range(4) != 0) ? 8'($urandom_range(19)) : 8'($urandom_range(255));
        r = $urandom_range(9);
        if (r < 5) op.prio = 16'($urandom_range(7));
        else if (r == 5) op.prio = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
        else op.prio = 16'($urandom_range(16'hFFFF));
        pending_ops.push_back(op);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every result to come back
    @(negedge clk);
    while (pending_ops.size() > 0 || in_tvalid || expected_results.size() > 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
